// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion helpers for the monitor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define WRBDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define WRBDM_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/core/wrbdm_pkg.sv -----
// ---------------------------------------------------------------------------
// wrbdm_pkg
// Shared types and constants of the windowed rate, bandwidth and delay monitor.
// ---------------------------------------------------------------------------
package wrbdm_pkg;

  localparam int unsigned WIN_MAX = 1024;
  localparam int unsigned PTR_W   = $clog2(WIN_MAX);
  localparam int unsigned CNT_W   = PTR_W + 1;
  localparam int unsigned SMP_W   = 64;
  localparam int unsigned SZ_W    = 32;
  localparam int unsigned TOT_W   = SZ_W + PTR_W;
  localparam int unsigned SUM_W   = SMP_W + PTR_W;
  localparam int unsigned DIV_NW  = SUM_W;
  localparam int unsigned DIV_DW  = SMP_W;
  localparam int unsigned DIV_CW  = $clog2(DIV_NW + 1);

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [46:0] RATE_K   = 47'd65536000000000;

  localparam logic [1:0] MODE_RATE  = 2'd0;
  localparam logic [1:0] MODE_BW    = 2'd1;
  localparam logic [1:0] MODE_DELAY = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [1:0] FUNC_ARRIVE = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_WLEN = 2'd1;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_REPORT,
    OP_CLEAR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [SMP_W-1:0]  sample;
    logic [SZ_W-1:0]   size;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] win;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] held;
  } stat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] win;
    logic [63:0]      rate;
    logic [63:0]      bps;
    logic [TOT_W-1:0] total;
    logic [63:0]      avg;
    logic [63:0]      dmin;
    logic [63:0]      dmax;
  } res_t;

endpackage

// ----- rtl/core/wrbdm_front.sv -----
// ---------------------------------------------------------------------------
// wrbdm_front
// Configuration registers, input acceptance and command classification.
// ---------------------------------------------------------------------------
module wrbdm_front import wrbdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [10:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       func_i,
  input  logic [62:0]      arrival_time_ns_i,
  input  logic [31:0]      message_bytes_i,
  input  logic [62:0]      header_stamp_ns_i,
  input  logic             stamp_valid_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             cmd_o,
  output cfg_t             cfg_o,
  output logic             clr_o
);

  logic [1:0]  mode_q;
  logic [10:0] wlen_q;
  logic        keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RATE;
      wlen_q <= 11'(WIN_MAX);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MODE) begin
        mode_q <= cfg_wdata_i[1:0];
      end else if (cfg_idx_i == REG_WLEN) begin
        wlen_q <= cfg_wdata_i;
      end
    end
  end

  assign clr_o    = cfg_we_i && (cfg_idx_i == REG_MODE || cfg_idx_i == REG_WLEN);

  always_comb begin
    cfg_o.mode = mode_q;
    if (wlen_q == 11'd0) begin
      cfg_o.win = CNT_W'(1);
    end else if (wlen_q > 11'(WIN_MAX)) begin
      cfg_o.win = CNT_W'(WIN_MAX);
    end else begin
      cfg_o.win = CNT_W'(wlen_q);
    end
  end

  always_comb begin
    keep        = 1'b0;
    cmd_o.op     = OP_PUSH;
    cmd_o.sample = {1'b0, arrival_time_ns_i};
    cmd_o.size   = message_bytes_i;
    unique case (func_i)
      FUNC_ARRIVE: begin
        if (mode_q == MODE_RATE || mode_q == MODE_BW) begin
          keep = 1'b1;
        end else if (mode_q == MODE_DELAY && stamp_valid_i) begin
          keep         = 1'b1;
          cmd_o.sample = {1'b0, arrival_time_ns_i} - {1'b0, header_stamp_ns_i};
          cmd_o.size   = '0;
        end
      end
      FUNC_REPORT: begin
        cmd_o.op = OP_REPORT;
        keep     = (mode_q != MODE_OFF);
      end
      FUNC_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

// ----- rtl/core/wrbdm_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// wrbdm_cmd_fifo
// Two-word command queue between the front and the back.
// ---------------------------------------------------------------------------
module wrbdm_cmd_fifo import wrbdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/core/wrbdm_div.sv -----
// ---------------------------------------------------------------------------
// wrbdm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wrbdm_div import wrbdm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], fits};
      rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/core/wrbdm_back.sv -----
// ---------------------------------------------------------------------------
// wrbdm_back
// Sample rings, window walk, statistics and result register.
// ---------------------------------------------------------------------------
module wrbdm_back import wrbdm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  clr_i,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  pop_o,
  output stat_t stat_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [SMP_W-1:0] mem_s [WIN_MAX];
  logic [SZ_W-1:0]  mem_z [WIN_MAX];

  logic [2:0]        state_q, state_d;
  logic [PTR_W-1:0]  wp_q, rd_addr_q;
  logic [CNT_W-1:0]  held_q, n_q, left_q;
  logic              rd_v_q, seen_q, neg_q, out_valid_q;
  logic [SMP_W-1:0]  smp_rd, first_q, last_q, span_q, dmin_q, dmax_q, rnum_q;
  logic [SZ_W-1:0]   sz_rd;
  logic [TOT_W-1:0]  tot_q;
  logic [SUM_W-1:0]  sum_q, mag_q;
  logic [50:0]       plo_q, phi_q;
  logic              wr_en, rd_en, start_rep, short_rep, load;
  logic [DIV_NW-1:0] div_num, quot;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [63:0]       q64;
  res_t              res_d, res_q;

  assign pop_o     = (state_q == S_IDLE) && cmd_valid_i;
  assign wr_en     = pop_o && cmd_i.op == OP_PUSH;
  assign start_rep = pop_o && cmd_i.op == OP_REPORT;
  assign short_rep = (cfg_i.mode == MODE_DELAY) ? (held_q == '0) : (held_q < CNT_W'(2));
  assign rd_en     = (state_q == S_WALK) && left_q != '0;
  assign load      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_s[wp_q] <= cmd_i.sample;
      mem_z[wp_q] <= cmd_i.size;
    end
    if (rd_en) begin
      smp_rd <= mem_s[rd_addr_q];
      sz_rd  <= mem_z[rd_addr_q];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_rep && !short_rep) state_d = S_WALK;
      S_WALK: if (left_q == '0 && !rd_v_q) state_d = S_EVAL;
      S_EVAL: begin
        if (cfg_i.mode != MODE_DELAY && !(last_q > first_q)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PREP;
        end
      end
      S_PREP: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      held_q      <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_en;
      if (clr_i || (pop_o && cmd_i.op == OP_CLEAR)) begin
        wp_q   <= '0;
        held_q <= '0;
      end else if (wr_en) begin
        wp_q   <= wp_q + PTR_W'(1);
        held_q <= (held_q >= cfg_i.win) ? cfg_i.win : held_q + CNT_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_rep) begin
      n_q       <= held_q;
      left_q    <= held_q;
      rd_addr_q <= wp_q - held_q[PTR_W-1:0];
      seen_q    <= 1'b0;
      tot_q     <= '0;
      sum_q     <= '0;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr_q + PTR_W'(1);
      left_q    <= left_q - CNT_W'(1);
    end
    if (rd_v_q) begin
      seen_q <= 1'b1;
      last_q <= smp_rd;
      tot_q  <= tot_q + TOT_W'(sz_rd);
      sum_q  <= sum_q + {{PTR_W{smp_rd[SMP_W-1]}}, smp_rd};
      if (!seen_q) begin
        first_q <= smp_rd;
        dmin_q  <= smp_rd;
        dmax_q  <= smp_rd;
      end else begin
        if ($signed(smp_rd) < $signed(dmin_q)) dmin_q <= smp_rd;
        if ($signed(smp_rd) > $signed(dmax_q)) dmax_q <= smp_rd;
      end
    end
    if (state_q == S_EVAL) begin
      span_q <= last_q - first_q;
      plo_q  <= 51'(tot_q[20:0]) * 51'(NS_PER_S);
      phi_q  <= 51'(tot_q[TOT_W-1:21]) * 51'(NS_PER_S);
      rnum_q <= 64'(58'(n_q - CNT_W'(1)) * 58'(RATE_K));
      neg_q  <= sum_q[SUM_W-1];
      mag_q  <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
    end
  end

  always_comb begin
    unique case (cfg_i.mode)
      MODE_RATE: begin
        div_num = DIV_NW'(rnum_q);
        div_den = span_q;
      end
      MODE_BW: begin
        div_num = DIV_NW'({phi_q, 21'd0}) + DIV_NW'(plo_q);
        div_den = span_q;
      end
      default: begin
        div_num = mag_q;
        div_den = DIV_DW'(n_q);
      end
    endcase
  end

  wrbdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PREP),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign q64 = quot[63:0];

  always_comb begin
    res_d       = '0;
    res_d.kind  = cfg_i.mode;
    res_d.count = n_q;
    res_d.win   = cfg_i.win;
    unique case (cfg_i.mode)
      MODE_RATE: res_d.rate = q64;
      MODE_BW: begin
        res_d.bps   = (quot[DIV_NW-1:64] != '0) ? '1 : q64;
        res_d.total = tot_q;
      end
      default: begin
        res_d.avg  = neg_q ? (~q64 + 64'd1) : q64;
        res_d.dmin = dmin_q;
        res_d.dmax = dmax_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign stat_o.held = held_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/windowed_rate_bandwidth_delay_monitor_top.sv -----
// Windowed rate, bandwidth and delay monitor. Arrivals, restarts and reports
// pass a two-word queue; an arrival makes one write to the sample memory in
// the back end. A report walks the n messages of the window through the single
// memory read port and then runs a 74-step restoring divider, holding the back
// end until its word is ready for the output register; meanwhile the queue
// takes two more words and then the input stalls, and a finished report waits
// until the output register is free.
// Writing either configuration register empties the window.
// ---------------------------------------------------------------------------
// windowed_rate_bandwidth_delay_monitor_top
// Top level: front, command queue and back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_rate_bandwidth_delay_monitor_top import wrbdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [62:0] arrival_time_ns_i,
  input  logic [31:0] message_bytes_i,
  input  logic [62:0] header_stamp_ns_i,
  input  logic        stamp_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  report_kind_o,
  output logic [10:0] sample_count_o,
  output logic [10:0] window_echo_o,
  output logic [63:0] rate_q16_o,
  output logic [63:0] byte_rate_o,
  output logic [41:0] byte_sum_o,
  output logic [63:0] avg_delay_ns_o,
  output logic [63:0] min_delay_ns_o,
  output logic [63:0] max_delay_ns_o
);

  cfg_t  cfg;
  stat_t stat;
  cmd_t  push_cmd, head_cmd;
  res_t  res;
  logic  clr, push, full, head_valid, pop;
  logic  dly_out, dly_ok, rate_out;

  wrbdm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .arrival_time_ns_i (arrival_time_ns_i),
    .message_bytes_i   (message_bytes_i),
    .header_stamp_ns_i (header_stamp_ns_i),
    .stamp_valid_i     (stamp_valid_i),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (push_cmd),
    .cfg_o             (cfg),
    .clr_o             (clr)
  );

  wrbdm_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head_cmd),
    .pop_i   (pop)
  );

  wrbdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clr_i       (clr),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign report_kind_o      = res.kind;
  assign sample_count_o     = res.count;
  assign window_echo_o      = res.win;
  assign rate_q16_o         = res.rate;
  assign byte_rate_o        = res.bps;
  assign byte_sum_o         = res.total;
  assign avg_delay_ns_o     = res.avg;
  assign min_delay_ns_o     = res.dmin;
  assign max_delay_ns_o     = res.dmax;

  assign dly_out  = out_valid_o && report_kind_o == MODE_DELAY;
  assign dly_ok   = $signed(min_delay_ns_o) <= $signed(max_delay_ns_o);
  assign rate_out = out_valid_o && report_kind_o != MODE_DELAY;

  `WRBDM_ASSERT(a_held_in_window, stat.held <= cfg.win, "held count exceeds window")
  `WRBDM_ASSERT_NEXT(a_cfg_clears, clr, stat.held == '0, "config write left samples")
  `WRBDM_ASSERT(a_delay_order, dly_out |-> dly_ok, "delay min above max")
  `WRBDM_ASSERT(a_report_span, rate_out |-> sample_count_o >= 11'd2, "rate report from short window")

endmodule

// ----- test/windowed_rate_bandwidth_delay_monitor_top_tb.sv -----
// ---------------------------------------------------------------------------
// windowed_rate_bandwidth_delay_monitor_top_tb
// Drives arrivals, restarts and report requests through the input channel
// under every statistics mode and a range of window lengths, predicts each
// report from a private copy of the sample window and compares it field by
// field with the words that leave the block, under random idling on both sides.
// ---------------------------------------------------------------------------
module windowed_rate_bandwidth_delay_monitor_top_tb import wrbdm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 1200;
  localparam int STALL_LIMIT  = 20000;
  localparam int EXP_DEPTH    = 16;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd2;

  class window_stats_scoreboard;
    logic [63:0] sample_mem[WIN_MAX];
    logic [31:0] size_mem[WIN_MAX];
    int unsigned wr_ptr, held;
    logic [1:0]  mode;
    logic [10:0] wlen;
    res_t        exp_mem[EXP_DEPTH];
    int unsigned exp_head, exp_tail, exp_cnt;
    int          errors, checked;

    function new();
      wr_ptr = 0; held = 0; mode = MODE_RATE; wlen = 11'd1024; errors = 0; checked = 0;
      exp_head = 0; exp_tail = 0; exp_cnt = 0;
    endfunction

    function int unsigned pending();
      return exp_cnt;
    endfunction

    function int unsigned eff_window();
      if (wlen < 1) return 1;
      if (wlen > WIN_MAX) return WIN_MAX;
      return wlen;
    endfunction

    function int unsigned slot(int unsigned back);
      return (wr_ptr + WIN_MAX - back) % WIN_MAX;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      if (idx == REG_MODE) begin
        mode = data[1:0]; wr_ptr = 0; held = 0;
      end else if (idx == REG_WLEN) begin
        wlen = data; wr_ptr = 0; held = 0;
      end
    endfunction

    function void store(logic [63:0] smp, logic [31:0] sz);
      sample_mem[wr_ptr] = smp;
      size_mem[wr_ptr] = sz;
      wr_ptr = (wr_ptr + 1) % WIN_MAX;
      if (held < eff_window()) held++;
    endfunction

    function void note_word(logic [1:0] f, logic [62:0] arr, logic [31:0] nbytes,
                            logic [62:0] stamp, logic svalid);
      res_t r;
      logic [63:0] first, last, span, tot;
      logic [127:0] prod, quo;
      logic signed [127:0] acc, avg;
      logic signed [63:0] sv, mn, mx;
      int n;
      n = held;
      if (f == FUNC_CLEAR) begin
        wr_ptr = 0; held = 0;
        return;
      end
      if (f == FUNC_ARRIVE) begin
        if (mode == MODE_RATE || mode == MODE_BW) store({1'b0, arr}, nbytes);
        else if (mode == MODE_DELAY && svalid) store({1'b0, arr} - {1'b0, stamp}, '0);
        return;
      end
      if (f != FUNC_REPORT || mode == MODE_OFF) return;
      r = '0;
      r.kind = mode;
      r.count = 11'(n);
      r.win = 11'(eff_window());
      if (mode != MODE_DELAY) begin
        if (n < 2) return;
        first = sample_mem[slot(n)];
        last = sample_mem[slot(1)];
        if (last <= first) return;
        span = last - first;
        if (mode == MODE_RATE) begin
          r.rate = (64'(n - 1) * 64'(RATE_K)) / span;
        end else begin
          tot = '0;
          for (int i = 1; i <= n; i++) tot += size_mem[slot(i)];
          prod = 128'(tot) * 128'(NS_PER_S);
          quo = prod / 128'(span);
          r.bps = (quo[127:64] != '0) ? '1 : quo[63:0];
          r.total = tot[41:0];
        end
      end else begin
        if (n == 0) return;
        acc = '0;
        mn = sample_mem[slot(1)];
        mx = mn;
        for (int i = 1; i <= n; i++) begin
          sv = sample_mem[slot(i)];
          acc += sv;
          if (sv < mn) mn = sv;
          if (sv > mx) mx = sv;
        end
        avg = acc / $signed(128'(n));
        r.avg = avg[63:0];
        r.dmin = mn;
        r.dmax = mx;
      end
      if (exp_cnt == EXP_DEPTH) begin
        $error("too many reports outstanding");
        errors++;
        return;
      end
      exp_mem[exp_tail] = r;
      exp_tail = (exp_tail + 1) % EXP_DEPTH;
      exp_cnt++;
    endfunction

    function void check_word(res_t got);
      res_t e;
      checked++;
      if (exp_cnt == 0) begin
        $error("unexpected report word: kind %0d count %0d", got.kind, got.count);
        errors++;
        return;
      end
      e = exp_mem[exp_head];
      exp_head = (exp_head + 1) % EXP_DEPTH;
      exp_cnt--;
      if (got.kind !== e.kind) begin
        $error("report_kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.count !== e.count) begin
        $error("sample_count: expected %0d actual %0d", e.count, got.count); errors++;
      end
      if (got.win !== e.win) begin
        $error("window_echo: expected %0d actual %0d", e.win, got.win); errors++;
      end
      if (got.rate !== e.rate) begin
        $error("rate_q16: expected %0d actual %0d", e.rate, got.rate); errors++;
      end
      if (got.bps !== e.bps) begin
        $error("byte_rate: expected %0d actual %0d", e.bps, got.bps); errors++;
      end
      if (got.total !== e.total) begin
        $error("byte_sum: expected %0d actual %0d", e.total, got.total); errors++;
      end
      if (got.avg !== e.avg) begin
        $error("avg_delay_ns: expected %0d actual %0d", $signed(e.avg), $signed(got.avg));
        errors++;
      end
      if (got.dmin !== e.dmin) begin
        $error("min_delay_ns: expected %0d actual %0d", $signed(e.dmin), $signed(got.dmin));
        errors++;
      end
      if (got.dmax !== e.dmax) begin
        $error("max_delay_ns: expected %0d actual %0d", $signed(e.dmax), $signed(got.dmax));
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = '0;
  logic [62:0] arrival_time_ns_i = '0;
  logic [31:0] message_bytes_i = '0;
  logic [62:0] header_stamp_ns_i = '0;
  logic        stamp_valid_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  report_kind_o;
  logic [10:0] sample_count_o;
  logic [10:0] window_echo_o;
  logic [63:0] rate_q16_o;
  logic [63:0] byte_rate_o;
  logic [41:0] byte_sum_o;
  logic [63:0] avg_delay_ns_o;
  logic [63:0] min_delay_ns_o;
  logic [63:0] max_delay_ns_o;

  window_stats_scoreboard sb = new();
  int  progress = 0;
  int  words_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  logic [62:0] now_ns = '0;

  windowed_rate_bandwidth_delay_monitor_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .func_i, .arrival_time_ns_i, .message_bytes_i,
    .header_stamp_ns_i, .stamp_valid_i, .out_valid_o, .out_ready_i,
    .report_kind_o, .sample_count_o, .window_echo_o, .rate_q16_o,
    .byte_rate_o, .byte_sum_o, .avg_delay_ns_o, .min_delay_ns_o,
    .max_delay_ns_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always begin
    res_t got;
    bit fire;
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      got.kind = report_kind_o;   got.count = sample_count_o; got.win = window_echo_o;
      got.rate = rate_q16_o;      got.bps = byte_rate_o;
      got.total = byte_sum_o;     got.avg = avg_delay_ns_o;
      got.dmin = min_delay_ns_o;  got.dmax = max_delay_ns_o;
      @(posedge clk_i);
      if (fire) begin
        sb.check_word(got);
        progress++;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always begin
    int idle, seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (progress != seen) begin
        seen = progress;
        idle = 0;
      end else if (++idle >= STALL_LIMIT) begin
        $display("windowed_rate_bandwidth_delay_monitor_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] f, logic [62:0] arr, logic [31:0] nbytes,
                           logic [62:0] stamp, logic svalid);
    bit acc;
    in_valid_i <= 1'b1;
    func_i <= f;
    arrival_time_ns_i <= arr;
    message_bytes_i <= nbytes;
    header_stamp_ns_i <= stamp;
    stamp_valid_i <= svalid;
    forever begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
      if (acc) break;
    end
    sb.note_word(f, arr, nbytes, stamp, svalid);
    words_sent++;
    progress++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    progress++;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    logic [1:0]  f;
    logic [62:0] arr, stamp;
    logic [31:0] nbytes;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) f = FUNC_ARRIVE;
    else if (pick < 94) f = FUNC_REPORT;
    else if (pick < 97) f = FUNC_CLEAR;
    else f = FUNC_SPARE;
    pick = $urandom_range(0, 99);
    if (pick < 85) now_ns = now_ns + 63'($urandom_range(1, 5000));
    else if (pick < 93) now_ns = 63'(now_ns + {$urandom, $urandom});
    else now_ns = 63'({$urandom, $urandom});
    arr = now_ns;
    nbytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    pick = $urandom_range(0, 9);
    if (pick < 6) stamp = arr - 63'($urandom_range(0, 100000));
    else if (pick < 8) stamp = arr + 63'($urandom_range(0, 100000));
    else stamp = 63'({$urandom, $urandom});
    send_word(f, arr, nbytes, stamp, $urandom_range(0, 9) != 0);
  endtask

  localparam logic [62:0] T_MAX = '1;
  localparam logic [31:0] B_MAX = '1;

  logic [1:0]  phase_mode[12] = '{MODE_RATE, MODE_BW, MODE_DELAY, MODE_RATE, MODE_BW,
                                   MODE_DELAY, MODE_OFF, MODE_RATE, MODE_BW, MODE_DELAY,
                                   MODE_DELAY, MODE_RATE};
  logic [10:0] phase_wlen[12] = '{11'd1, 11'd2, 11'd4, 11'd8, 11'd16, 11'd1024, 11'd5,
                                   11'd0, 11'd2047, 11'd3, 11'd1025, 11'd8};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, '0, B_MAX, T_MAX, 1'b1);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, '0, '0, '0, 1'b0);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, T_MAX, B_MAX, '0, 1'b1);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_SPARE, T_MAX, B_MAX, T_MAX, 1'b1);
    send_word(FUNC_CLEAR, '0, '0, '0, 1'b0);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    settle();
    write_reg(REG_MODE, {9'd0, MODE_BW});
    send_word(FUNC_ARRIVE, 63'd0, B_MAX, '0, 1'b0);
    send_word(FUNC_ARRIVE, 63'd1, B_MAX, '0, 1'b0);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, 63'd0, 32'd1, '0, 1'b0);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    settle();
    write_reg(REG_MODE, {9'd0, MODE_DELAY});
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, T_MAX, '0, '0, 1'b0);
    send_word(FUNC_ARRIVE, '0, '0, T_MAX, 1'b1);
    send_word(FUNC_ARRIVE, T_MAX, '0, '0, 1'b1);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    settle();
    write_reg(REG_MODE, {9'd0, MODE_OFF});
    send_word(FUNC_ARRIVE, 63'd5, 32'd7, '0, 1'b1);
    send_word(FUNC_REPORT, '0, '0, '0, 1'b0);
    settle();
    write_reg(REG_SPARE, 11'h7FF);

    for (int p = 0; p < 12; p++) begin
      settle();
      write_reg(REG_WLEN, phase_wlen[p]);
      write_reg(REG_MODE, {9'd0, phase_mode[p]});
      if (p == 11) hold_req = 1'b1;
      for (int k = 0; k < 106; k++) begin
        if (p == 11 && k == 60) quiet = 1'b1;
        random_word();
      end
    end

    settle();
    if (sb.pending() != 0) begin
      $error("%0d expected reports never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d input words over all four modes and twelve window settings,",
             words_sent);
    $display("and compared %0d report words against the predicted window statistics.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("windowed_rate_bandwidth_delay_monitor_top_tb: clean");
    end else begin
      $display("windowed_rate_bandwidth_delay_monitor_top_tb: errors");
    end
    $finish;
  end

endmodule
